>>> design/kuf_pkg.sv
// ----------------------------------------------------------------------------
// kuf_pkg: shared definitions for the union-find edge filter
// Field widths, stream word layout and the accumulator command type.
// ----------------------------------------------------------------------------
`default_nettype none

package kuf_pkg;

    localparam int EP_W         = 10;
    localparam int WEIGHT_W     = 32;
    localparam int TOTAL_W      = 48;
    localparam int VERTICES_DEF = 1024;

    // Input word: endpoint_a, endpoint_b, edge_weight, padded to whole bytes.
    localparam int IN_BITS     = 2 * EP_W + WEIGHT_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int A_LSB       = 0;
    localparam int B_LSB       = EP_W;
    localparam int W_LSB       = 2 * EP_W;

    // Output word: edge_taken, tree_weight, padded to whole bytes.
    localparam int OUT_BITS    = 1 + TOTAL_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic                add;
        logic [WEIGHT_W-1:0] weight;
    } acc_cmd_t;

endpackage

`default_nettype wire

>>> design/kruskal_union_find_edge_filter.sv
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter: Kruskal edge acceptance with union-find
// Sequencer over one parent/size RAM with path compression and union by size.
// ----------------------------------------------------------------------------
// After reset the block initializes all VERTICES entries of the union-find
// RAM and takes no word meanwhile. Edges are then handled one at a time.
// An edge is first accepted. For each endpoint the block then walks the
// parent links to the root and sees the root, then rewrites each node on
// the path during path compression and closes that pass. Linking two
// distinct roots takes a link step and a size step, and the result is then
// handed over. Endpoints that already share a root skip the linking, and
// an edge with an endpoint out of range goes straight to the hand-over.
// The single RAM read port walks one parent link per cycle. A finished
// result sits in an output register, so the next edge is taken while it
// waits. The hand-over stalls as long as the previous result is still
// waiting.
`default_nettype none

module kruskal_union_find_edge_filter #(
    parameter int VERTICES = kuf_pkg::VERTICES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [9:0] endpoint_a, [19:10] endpoint_b, [51:20] edge_weight, rest zero
    input  wire logic [kuf_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [0] edge_taken, [48:1] tree_weight, rest zero
    output logic      [kuf_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int VW = $clog2(VERTICES);
    localparam int CW = VW + 1;
    localparam int XW = (VW + 1 > kuf_pkg::EP_W + 1) ? VW + 1 : kuf_pkg::EP_W + 1;
    localparam int RW = VW + CW;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK_A,
        S_COMP_A,
        S_WALK_B,
        S_COMP_B,
        S_LINK,
        S_GROW,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [VW-1:0]               clr_reg, clr_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic                        out_taken_reg, out_taken_next;
    logic [kuf_pkg::TOTAL_W-1:0] out_total_reg, out_total_next;

    logic [VW-1:0]               node_reg, node_next;
    logic [VW-1:0]               a_reg, a_next;
    logic [VW-1:0]               b_reg, b_next;
    logic [kuf_pkg::WEIGHT_W-1:0] w_reg, w_next;
    logic [VW-1:0]               root_a_reg, root_a_next;
    logic [VW-1:0]               root_b_reg, root_b_next;
    logic [CW-1:0]               size_a_reg, size_a_next;
    logic [CW-1:0]               size_b_reg, size_b_next;
    logic                        taken_reg, taken_next;

    logic                        ram_we;
    logic [VW-1:0]               ram_waddr;
    logic [RW-1:0]               ram_wdata;
    logic [VW-1:0]               ram_raddr;
    logic [RW-1:0]               ram_rdata;
    logic [VW-1:0]               rd_parent;
    logic [CW-1:0]               rd_size;

    logic [kuf_pkg::EP_W-1:0]    in_a;
    logic [kuf_pkg::EP_W-1:0]    in_b;
    logic                        in_range;
    logic                        in_accept;
    logic                        b_bigger;
    logic                        out_free;

    kuf_pkg::acc_cmd_t           acc_cmd;
    logic [kuf_pkg::TOTAL_W-1:0] total;

    kuf_ram #(
        .WIDTH (RW),
        .DEPTH (VERTICES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kuf_total u_total (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (acc_cmd),
        .total (total)
    );

    assign rd_parent = ram_rdata[VW-1:0];
    assign rd_size   = ram_rdata[RW-1:VW];

    assign in_a = s_tdata[kuf_pkg::A_LSB +: kuf_pkg::EP_W];
    assign in_b = s_tdata[kuf_pkg::B_LSB +: kuf_pkg::EP_W];
    assign in_range = (XW'(in_a) < XW'(VERTICES)) && (XW'(in_b) < XW'(VERTICES));

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign b_bigger  = size_b_reg > size_a_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        m_tvalid_next  = m_tvalid_reg;
        out_taken_next = out_taken_reg;
        out_total_next = out_total_reg;
        node_next      = node_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        w_next         = w_reg;
        root_a_next    = root_a_reg;
        root_b_next    = root_b_reg;
        size_a_next    = size_a_reg;
        size_b_next    = size_b_reg;
        taken_next     = taken_reg;
        ram_we         = 1'b0;
        ram_waddr      = node_reg;
        ram_wdata      = {rd_size, root_a_reg};
        ram_raddr      = node_reg;
        acc_cmd.add    = 1'b0;
        acc_cmd.weight = w_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                // Every vertex starts as the root of a set of size one.
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = {CW'(1), clr_reg};
                clr_next  = clr_reg + VW'(1);
                if (clr_reg == VW'(VERTICES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    a_next     = VW'(in_a);
                    b_next     = VW'(in_b);
                    w_next     = s_tdata[kuf_pkg::W_LSB +: kuf_pkg::WEIGHT_W];
                    taken_next = 1'b0;
                    node_next  = VW'(in_a);
                    ram_raddr  = VW'(in_a);
                    state_next = in_range ? S_WALK_A : S_DONE;
                end
            end
            S_WALK_A:
            begin
                if (rd_parent == node_reg)
                begin
                    root_a_next = node_reg;
                    size_a_next = rd_size;
                    node_next   = a_reg;
                    ram_raddr   = a_reg;
                    state_next  = S_COMP_A;
                end
                else
                begin
                    node_next = rd_parent;
                    ram_raddr = rd_parent;
                end
            end
            S_COMP_A:
            begin
                if (node_reg == root_a_reg)
                begin
                    node_next  = b_reg;
                    ram_raddr  = b_reg;
                    state_next = S_WALK_B;
                end
                else
                begin
                    // Point this node straight at the root, then follow its old link.
                    ram_we    = 1'b1;
                    ram_waddr = node_reg;
                    ram_wdata = {rd_size, root_a_reg};
                    node_next = rd_parent;
                    ram_raddr = rd_parent;
                end
            end
            S_WALK_B:
            begin
                if (rd_parent == node_reg)
                begin
                    root_b_next = node_reg;
                    size_b_next = rd_size;
                    node_next   = b_reg;
                    ram_raddr   = b_reg;
                    state_next  = S_COMP_B;
                end
                else
                begin
                    node_next = rd_parent;
                    ram_raddr = rd_parent;
                end
            end
            S_COMP_B:
            begin
                if (node_reg == root_b_reg)
                begin
                    state_next = (root_a_reg == root_b_reg) ? S_DONE : S_LINK;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = node_reg;
                    ram_wdata = {rd_size, root_b_reg};
                    node_next = rd_parent;
                    ram_raddr = rd_parent;
                end
            end
            S_LINK:
            begin
                // On equal sizes the root of endpoint_a stays root.
                ram_we      = 1'b1;
                ram_waddr   = b_bigger ? root_a_reg : root_b_reg;
                ram_wdata   = b_bigger ? {size_a_reg, root_b_reg}
                                       : {size_b_reg, root_a_reg};
                acc_cmd.add = 1'b1;
                taken_next  = 1'b1;
                state_next  = S_GROW;
            end
            S_GROW:
            begin
                ram_we     = 1'b1;
                ram_waddr  = b_bigger ? root_b_reg : root_a_reg;
                ram_wdata  = {size_a_reg + size_b_reg,
                              b_bigger ? root_b_reg : root_a_reg};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next  = 1'b1;
                    out_taken_next = taken_reg;
                    out_total_next = total;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
            out_taken_reg <= 1'b0;
            out_total_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            m_tvalid_reg  <= m_tvalid_next;
            out_taken_reg <= out_taken_next;
            out_total_reg <= out_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        w_reg      <= w_next;
        root_a_reg <= root_a_next;
        root_b_reg <= root_b_next;
        size_a_reg <= size_a_next;
        size_b_reg <= size_b_next;
        taken_reg  <= taken_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = kuf_pkg::OUT_TDATA_W'({out_total_reg, out_taken_reg});

    // The running total only ever grows.
    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        total >= $past(total))
        else $error("running total decreased");

    // The store is never written while the block offers to take a word.
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !ram_we)
        else $error("RAM write while idle");

    // Linking only happens between two distinct roots.
    a_link_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINK) |-> (root_a_reg != root_b_reg))
        else $error("link of a set with itself");

    // An edge with an endpoint out of range goes straight to the result.
    a_range_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !in_range) |=> (state_reg == S_DONE) && !taken_reg)
        else $error("out-of-range edge entered the walk");

endmodule

`default_nettype wire

>>> design/kuf_ram.sv
// ----------------------------------------------------------------------------
// kuf_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module kuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> design/kuf_total.sv
// ----------------------------------------------------------------------------
// kuf_total: saturating running total of taken edge weights
// Adds one weight per command and clamps at the largest 48-bit value.
// ----------------------------------------------------------------------------
`default_nettype none

module kuf_total (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire kuf_pkg::acc_cmd_t       cmd,
    output logic [kuf_pkg::TOTAL_W-1:0]  total
);

    logic [kuf_pkg::TOTAL_W-1:0] total_reg;
    logic [kuf_pkg::TOTAL_W-1:0] total_next;
    logic [kuf_pkg::TOTAL_W:0]   sum;

    always_comb
    begin
        sum = {1'b0, total_reg} + (kuf_pkg::TOTAL_W + 1)'(cmd.weight);
        total_next = total_reg;
        if (cmd.add)
        begin
            // A carry out of the top bit means the sum passed the maximum.
            total_next = sum[kuf_pkg::TOTAL_W] ? '1 : sum[kuf_pkg::TOTAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else
        begin
            total_reg <= total_next;
        end
    end

    assign total = total_reg;

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the Kruskal union-find edge filter
// Edge words go in on the slave stream and verdict words come out on the
// master stream. A forest tracker keeps its own parent and size tables,
// predicts each verdict and compares it, field by field, in arrival order.
// ----------------------------------------------------------------------------

module tb;

    typedef struct {
        logic                        taken;
        logic [kuf_pkg::TOTAL_W-1:0] total;
    } verdict_t;

    // Disjoint-set tracker: predicts the verdict of every accepted edge.
    class forest_tracker;
        logic [kuf_pkg::EP_W-1:0]    parent [kuf_pkg::VERTICES_DEF];
        logic [kuf_pkg::EP_W:0]      members [kuf_pkg::VERTICES_DEF];
        logic [kuf_pkg::TOTAL_W-1:0] tree_total;
        verdict_t                    awaited [$];
        int                          mismatch_count;

        function new();
            for (int i = 0; i < kuf_pkg::VERTICES_DEF; i++)
            begin
                parent[i]  = kuf_pkg::EP_W'(i);
                members[i] = (kuf_pkg::EP_W + 1)'(1);
            end
            tree_total     = '0;
            mismatch_count = 0;
        endfunction

        // Walk to the root, then point every node on the path at it.
        function logic [kuf_pkg::EP_W-1:0] root_of(logic [kuf_pkg::EP_W-1:0] v);
            logic [kuf_pkg::EP_W-1:0] r;
            logic [kuf_pkg::EP_W-1:0] nxt;
            r = v;
            while (parent[r] != r)
                r = parent[r];
            while (v != r)
            begin
                nxt       = parent[v];
                parent[v] = r;
                v         = nxt;
            end
            return r;
        endfunction

        function void take_edge(logic [kuf_pkg::EP_W-1:0] a, logic [kuf_pkg::EP_W-1:0] b,
                                logic [kuf_pkg::WEIGHT_W-1:0] w);
            logic [kuf_pkg::EP_W-1:0]  ra;
            logic [kuf_pkg::EP_W-1:0]  rb;
            logic [kuf_pkg::EP_W-1:0]  swap;
            logic [kuf_pkg::TOTAL_W:0] sum;
            verdict_t                  v;
            v.taken = 1'b0;
            if (a < kuf_pkg::VERTICES_DEF && b < kuf_pkg::VERTICES_DEF)
            begin
                ra = root_of(a);
                rb = root_of(b);
                if (ra != rb)
                begin
                    // The larger set keeps its root; on a tie endpoint_a's root wins.
                    if (members[rb] > members[ra])
                    begin
                        swap = ra;
                        ra   = rb;
                        rb   = swap;
                    end
                    members[ra] = members[ra] + members[rb];
                    parent[rb]  = ra;
                    sum = {1'b0, tree_total} + (kuf_pkg::TOTAL_W + 1)'(w);
                    if (sum[kuf_pkg::TOTAL_W])
                        tree_total = '1;
                    else
                        tree_total = sum[kuf_pkg::TOTAL_W-1:0];
                    v.taken = 1'b1;
                end
            end
            v.total = tree_total;
            awaited.insert(awaited.size(), v);
        endfunction

        function void match_result(logic taken, logic [kuf_pkg::TOTAL_W-1:0] total);
            verdict_t exp_v;
            if (awaited.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected word taken=%0b total=%0d", $realtime,
                             taken, total);
                return;
            end
            exp_v = awaited.pop_front();
            if (taken !== exp_v.taken)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: edge_taken expected %0b got %0b", $realtime,
                             exp_v.taken, taken);
            end
            if (total !== exp_v.total)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: tree_weight expected %0d got %0d", $realtime,
                             exp_v.total, total);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [kuf_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [kuf_pkg::OUT_TDATA_W-1:0] m_tdata;

    forest_tracker forest;
    bit            steady_flow;

    kruskal_union_find_edge_filter DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Result side: back-pressure unless steady_flow, checks every accepted word.
    always @(negedge clk)
    begin
        m_tready <= rst_n && (steady_flow || $urandom_range(0, 99) >= 36);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            forest.match_result(m_tdata[0], m_tdata[kuf_pkg::TOTAL_W:1]);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_edge(input logic [kuf_pkg::EP_W-1:0] a,
                             input logic [kuf_pkg::EP_W-1:0] b,
                             input logic [kuf_pkg::WEIGHT_W-1:0] w);
        logic [kuf_pkg::IN_TDATA_W-1:0] word;
        word = '0;
        word[kuf_pkg::A_LSB +: kuf_pkg::EP_W]     = a;
        word[kuf_pkg::B_LSB +: kuf_pkg::EP_W]     = b;
        word[kuf_pkg::W_LSB +: kuf_pkg::WEIGHT_W] = w;
        while (!steady_flow && $urandom_range(0, 99) < 36)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
        forest.take_edge(a, b, w);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (forest.pending() != 0);
    endtask

    function automatic logic [kuf_pkg::WEIGHT_W-1:0] bump(logic [kuf_pkg::WEIGHT_W-1:0] w);
        logic [kuf_pkg::WEIGHT_W:0] nxt;
        nxt = {1'b0, w} + (kuf_pkg::WEIGHT_W + 1)'($urandom_range(0, 5000));
        return nxt[kuf_pkg::WEIGHT_W] ? '1 : nxt[kuf_pkg::WEIGHT_W-1:0];
    endfunction

    initial
    begin
        logic [kuf_pkg::WEIGHT_W-1:0] weight_cursor;
        int                           base;
        forest      = new();
        steady_flow = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero and maximum weights, reversed duplicate, self loops,
        // both size orderings, a size tie, and chains that need compressing.
        send_edge(10'd0,    10'd1,    32'd0);
        send_edge(10'd1,    10'd0,    32'd5);
        send_edge(10'd7,    10'd7,    32'd10);
        send_edge(10'd1023, 10'd1022, 32'hFFFF_FFFF);
        send_edge(10'd1023, 10'd1023, 32'hFFFF_FFFF);
        send_edge(10'd2,    10'd0,    32'd20);
        send_edge(10'd3,    10'd4,    32'd21);
        send_edge(10'd4,    10'd2,    32'd22);
        send_edge(10'd5,    10'd6,    32'd23);
        send_edge(10'd8,    10'd5,    32'd24);
        send_edge(10'd9,    10'd8,    32'd25);
        send_edge(10'd3,    10'd9,    32'd26);
        send_edge(10'd6,    10'd1,    32'd27);
        send_edge(10'd1022, 10'd0,    32'd28);
        send_edge(10'd512,  10'd511,  32'd29);
        send_edge(10'd0,    10'd512,  32'h8000_0000);
        send_edge(10'd1023, 10'd9,    32'hFFFF_FFFE);
        send_edge(10'd511,  10'd4,    32'hFFFF_FFFF);

        // Kruskal-like runs: ascending weights inside small vertex windows,
        // with some stray edges of any weight mixed in.
        for (int win = 0; win < 60; win++)
        begin
            steady_flow   = (win >= 20 && win < 30);
            base          = 16 + win * 16;
            weight_cursor = $urandom >> $urandom_range(1, 8);
            for (int k = 0; k < 12; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_edge(kuf_pkg::EP_W'($urandom), kuf_pkg::EP_W'($urandom),
                              $urandom);
                end
                else
                begin
                    weight_cursor = bump(weight_cursor);
                    send_edge(kuf_pkg::EP_W'(base + $urandom_range(0, 15)),
                              kuf_pkg::EP_W'(base + $urandom_range(0, 15)),
                              weight_cursor);
                end
            end
            if (win == 30)
                drain_results();
        end
        steady_flow = 1'b0;

        // Joining pass over the whole vertex range.
        weight_cursor = $urandom >> 2;
        for (int k = 0; k < 380; k++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_edge(kuf_pkg::EP_W'($urandom), kuf_pkg::EP_W'($urandom), $urandom);
            end
            else
            begin
                weight_cursor = bump(weight_cursor);
                send_edge(kuf_pkg::EP_W'($urandom), kuf_pkg::EP_W'($urandom),
                          weight_cursor);
            end
        end

        drain_results();
        repeat (64) @(posedge clk);
        if (forest.mismatch_count == 0 && forest.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
